### src/qva_pkg.sv
// ----------------------------------------------------------------------------
// qva_pkg
// Shared types, widths and helpers for the quaternion / vector ALU.
// ----------------------------------------------------------------------------
package qva_pkg;

    localparam int COMP_WIDTH = 16;
    localparam int FRAC_BITS  = 12;

    // product, exact level-one sum, level-one entry, level-two sum widths
    localparam int PW   = 2 * COMP_WIDTH;
    localparam int SW   = 2 * COMP_WIDTH + 3;
    localparam int L1W  = 2 * COMP_WIDTH + 2 - FRAC_BITS;
    localparam int P2W  = L1W + COMP_WIDTH;
    localparam int S2W  = P2W + 2;
    localparam int RW   = SW;

    localparam logic signed [RW-1:0] CMAX = RW'((64'sd1 <<< (COMP_WIDTH - 1)) - 64'sd1);
    localparam logic signed [RW-1:0] CMIN = -CMAX - RW'(1);

    typedef enum logic [3:0] {
        OP_ADD     = 4'd0,
        OP_SUB     = 4'd1,
        OP_QMUL    = 4'd2,
        OP_CONJ    = 4'd3,
        OP_SCALE   = 4'd4,
        OP_NORM2   = 4'd5,
        OP_ROT     = 4'd6,
        OP_INVROT  = 4'd7,
        OP_CROSS   = 4'd8,
        OP_DOT     = 4'd9,
        OP_COMPMUL = 4'd10
    } t_op;

    typedef logic signed [COMP_WIDTH-1:0] t_comp;
    typedef logic signed [RW-1:0]         t_wide;

    typedef struct packed {
        t_comp value;
        logic  hit;
    } t_sat;

    // floor shift of an exact level-one sum
    function automatic t_wide fsh_wide(input logic signed [SW-1:0] s);
        logic signed [SW-1:0] sh;
        sh = s >>> FRAC_BITS;
        return RW'(sh);
    endfunction

    // clip to the component range and report clipping
    function automatic t_sat clip(input t_wide v);
        t_sat res;
        if (v > CMAX) begin
            res.value = COMP_WIDTH'(CMAX);
            res.hit   = 1'b1;
        end else if (v < CMIN) begin
            res.value = COMP_WIDTH'(CMIN);
            res.hit   = 1'b1;
        end else begin
            res.value = COMP_WIDTH'(v);
            res.hit   = 1'b0;
        end
        return res;
    endfunction

endpackage

### src/qva_req_if.sv
// ----------------------------------------------------------------------------
// qva_req_if
// Request channel: operation code and two quaternions.
// ----------------------------------------------------------------------------
interface qva_req_if
    import qva_pkg::*;
();
    logic        valid;
    logic        ready;
    logic [3:0]  req_type;
    t_comp       a_real;
    t_comp       a_i;
    t_comp       a_j;
    t_comp       a_k;
    t_comp       b_real;
    t_comp       b_i;
    t_comp       b_j;
    t_comp       b_k;

    modport source (output valid, req_type, a_real, a_i, a_j, a_k,
                    b_real, b_i, b_j, b_k, input ready);
    modport sink   (input valid, req_type, a_real, a_i, a_j, a_k,
                    b_real, b_i, b_j, b_k, output ready);
endinterface

### src/qva_rsp_if.sv
// ----------------------------------------------------------------------------
// qva_rsp_if
// Result channel: one quaternion and a saturation flag.
// ----------------------------------------------------------------------------
interface qva_rsp_if
    import qva_pkg::*;
();
    logic  valid;
    logic  ready;
    t_comp out_real;
    t_comp out_i;
    t_comp out_j;
    t_comp out_k;
    logic  saturated;

    modport source (output valid, out_real, out_i, out_j, out_k, saturated,
                    input ready);
    modport sink   (input valid, out_real, out_i, out_j, out_k, saturated,
                    output ready);
endinterface

### src/quaternion_vector_alu_core.sv
// Throughput: one word per cycle; the five register stages (operands,
// products, level-one sums, matrix products, saturated output) advance together.
// A stalled output holds the whole pipeline.
// Reset (i_rst_n, synchronous, active low) clears the stage valid bits only.
// ----------------------------------------------------------------------------
// quaternion_vector_alu_core
// Pipelined quaternion and 3-vector arithmetic in signed fixed point with
// floor rounding per multiply level and output saturation.
// ----------------------------------------------------------------------------
module quaternion_vector_alu_core
    import qva_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    qva_req_if.sink     i_req,
    qva_rsp_if.source   o_rsp
);

    localparam int NST = 5;

    logic [NST-1:0] r_v;
    logic           ce;

    // advance all stages when the output slot is free or being taken
    assign ce          = !r_v[NST-1] || o_rsp.ready;
    assign i_req.ready = ce && i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (ce) begin
            r_v <= {r_v[NST-2:0], i_req.valid};
        end
    end

    // stage A: capture operands
    logic [3:0] r_op_a;
    t_comp      r_a_a [4];
    t_comp      r_b_a [4];

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_op_a   <= i_req.req_type;
            r_a_a[0] <= i_req.a_real;
            r_a_a[1] <= i_req.a_i;
            r_a_a[2] <= i_req.a_j;
            r_a_a[3] <= i_req.a_k;
            r_b_a[0] <= i_req.b_real;
            r_b_a[1] <= i_req.b_i;
            r_b_a[2] <= i_req.b_j;
            r_b_a[3] <= i_req.b_k;
        end
    end

    // stage B: all a*b and a*a products
    logic [3:0]           r_op_b;
    t_comp                r_a_b [4];
    t_comp                r_b_b [4];
    logic signed [PW-1:0] r_pab [4][4];
    logic signed [PW-1:0] r_paa [4][4];

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_op_b <= r_op_a;
            for (int i = 0; i < 4; i++) begin
                r_a_b[i] <= r_a_a[i];
                r_b_b[i] <= r_b_a[i];
                for (int j = 0; j < 4; j++) begin
                    r_pab[i][j] <= PW'(r_a_a[i] * r_b_a[j]);
                    r_paa[i][j] <= PW'(r_a_a[i] * r_a_a[j]);
                end
            end
        end
    end

    // stage C: level-one sums, floor shift, matrix entries
    logic signed [SW-1:0] p [4][4];
    logic signed [SW-1:0] q [4][4];
    logic signed [SW-1:0] ms [9];
    t_wide                n_res [4];
    logic                 n_rot;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                p[i][j] = SW'(r_pab[i][j]);
                q[i][j] = SW'(r_paa[i][j]);
            end
        end
        ms[0] = q[0][0] + q[1][1] - q[2][2] - q[3][3];
        ms[1] = (q[1][2] - q[0][3]) <<< 1;
        ms[2] = (q[0][2] + q[1][3]) <<< 1;
        ms[3] = (q[0][3] + q[1][2]) <<< 1;
        ms[4] = q[0][0] - q[1][1] + q[2][2] - q[3][3];
        ms[5] = (q[2][3] - q[0][1]) <<< 1;
        ms[6] = (q[1][3] - q[0][2]) <<< 1;
        ms[7] = (q[0][1] + q[2][3]) <<< 1;
        ms[8] = q[0][0] - q[1][1] - q[2][2] + q[3][3];

        for (int i = 0; i < 4; i++) n_res[i] = '0;
        n_rot = 1'b0;
        unique case (r_op_b)
            OP_ADD: begin
                for (int i = 0; i < 4; i++) n_res[i] = RW'(r_a_b[i]) + RW'(r_b_b[i]);
            end
            OP_SUB: begin
                for (int i = 0; i < 4; i++) n_res[i] = RW'(r_a_b[i]) - RW'(r_b_b[i]);
            end
            OP_QMUL: begin
                n_res[0] = fsh_wide(p[0][0] - p[1][1] - p[2][2] - p[3][3]);
                n_res[1] = fsh_wide(p[1][0] + p[0][1] - p[3][2] + p[2][3]);
                n_res[2] = fsh_wide(p[2][0] + p[3][1] + p[0][2] - p[1][3]);
                n_res[3] = fsh_wide(p[3][0] - p[2][1] + p[1][2] + p[0][3]);
            end
            OP_CONJ: begin
                n_res[0] = RW'(r_a_b[0]);
                for (int i = 1; i < 4; i++) n_res[i] = -RW'(r_a_b[i]);
            end
            OP_SCALE: begin
                for (int i = 0; i < 4; i++) n_res[i] = fsh_wide(p[i][0]);
            end
            OP_NORM2: begin
                n_res[0] = fsh_wide(q[0][0] + q[1][1] + q[2][2] + q[3][3]);
            end
            OP_ROT, OP_INVROT: begin
                n_rot = 1'b1;
            end
            OP_CROSS: begin
                n_res[1] = fsh_wide(p[2][3] - p[3][2]);
                n_res[2] = fsh_wide(p[3][1] - p[1][3]);
                n_res[3] = fsh_wide(p[1][2] - p[2][1]);
            end
            OP_DOT: begin
                n_res[0] = fsh_wide(p[1][1] + p[2][2] + p[3][3]);
            end
            OP_COMPMUL: begin
                for (int i = 1; i < 4; i++) n_res[i] = fsh_wide(p[i][i]);
            end
            default: ;
        endcase
    end

    logic [3:0]            r_op_c;
    logic                  r_rot_c;
    t_comp                 r_b_c [3];
    t_wide                 r_res_c [4];
    logic signed [L1W-1:0] r_m_c [9];

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_op_c  <= r_op_b;
            r_rot_c <= n_rot;
            for (int i = 0; i < 3; i++) r_b_c[i] <= r_b_b[i+1];
            for (int i = 0; i < 4; i++) r_res_c[i] <= n_res[i];
            for (int i = 0; i < 9; i++) r_m_c[i] <= L1W'(fsh_wide(ms[i]));
        end
    end

    // stage D: matrix or transposed matrix times vector b
    logic signed [L1W-1:0] mt [3][3];
    logic signed [P2W-1:0] r_pm [3][3];
    logic                  r_rot_d;
    t_wide                 r_res_d [4];

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                mt[r][c] = (r_op_c == OP_INVROT) ? r_m_c[c*3 + r] : r_m_c[r*3 + c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_rot_d <= r_rot_c;
            for (int i = 0; i < 4; i++) r_res_d[i] <= r_res_c[i];
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_pm[r][c] <= P2W'(mt[r][c] * r_b_c[c]);
                end
            end
        end
    end

    // stage E: level-two sums, select, saturate
    logic signed [S2W-1:0] rs [3];
    t_wide                 fin [4];
    t_sat                  sat [4];

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            rs[r] = (S2W'(r_pm[r][0]) + S2W'(r_pm[r][1]) + S2W'(r_pm[r][2])) >>> FRAC_BITS;
        end
        fin[0] = r_rot_d ? '0 : r_res_d[0];
        for (int i = 1; i < 4; i++) begin
            fin[i] = r_rot_d ? RW'(rs[i-1]) : r_res_d[i];
        end
        for (int i = 0; i < 4; i++) sat[i] = clip(fin[i]);
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            o_rsp.out_real  <= sat[0].value;
            o_rsp.out_i     <= sat[1].value;
            o_rsp.out_j     <= sat[2].value;
            o_rsp.out_k     <= sat[3].value;
            o_rsp.saturated <= sat[0].hit | sat[1].hit | sat[2].hit | sat[3].hit;
        end
    end

    assign o_rsp.valid = r_v[NST-1];

    // a held output stalls the request side
    a_stall_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.ready) |-> !i_req.ready)
        else $error("request accepted while output stalled");

    // a flagged result has a clipped component
    a_sat_clipped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.saturated) |->
        (o_rsp.out_real == COMP_WIDTH'(CMAX) || o_rsp.out_real == COMP_WIDTH'(CMIN) ||
         o_rsp.out_i == COMP_WIDTH'(CMAX) || o_rsp.out_i == COMP_WIDTH'(CMIN) ||
         o_rsp.out_j == COMP_WIDTH'(CMAX) || o_rsp.out_j == COMP_WIDTH'(CMIN) ||
         o_rsp.out_k == COMP_WIDTH'(CMAX) || o_rsp.out_k == COMP_WIDTH'(CMIN)))
        else $error("saturation flag without clipped component");

    // the valid of the second-to-last stage moves into the last stage when the pipeline advances
    a_valid_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ce && r_v[NST-2]) |=> r_v[NST-1])
        else $error("word lost between last two stages");

    // nothing valid right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_rsp.valid)
        else $error("output valid right after reset");

endmodule

### dv/quaternion_vector_alu_core_tb.sv
// ----------------------------------------------------------------------------
// quaternion_vector_alu_core_tb
// Drives request words into the quaternion / vector ALU with random gaps,
// computes the expected result word of each untyped request in a local
// fixed-point model and compares every result word field by field in order of acceptance.
// ----------------------------------------------------------------------------
module quaternion_vector_alu_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import qva_pkg::*;

    localparam int N_RANDOM    = 1200;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 20;

    typedef struct {
        logic [3:0]    op;
        t_comp         a [4];
        t_comp         b [4];
    } t_req;

    typedef struct {
        t_comp         q [4];
        logic          sat;
    } t_result;

    typedef struct {
        t_req          req;
        bit            typed;
        t_result       res;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    int   cycle_cnt;
    int   err_cnt;
    bit   send_done;
    bit   hold_off;

    qva_req_if i_req ();
    qva_rsp_if o_rsp ();

    t_result pending_results [$];
    t_row    directed_rows [$];

    quaternion_vector_alu_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_rsp   (o_rsp)
    );

    // clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // floor shift by the fraction width
    function automatic longint floor_frac(input longint v);
        return v >>> FRAC_BITS;
    endfunction

    // clip one component and record any clipping
    function automatic t_comp clamp_comp(input longint v, inout logic hit);
        longint hi;
        hi = (longint'(1) <<< (COMP_WIDTH - 1)) - 1;
        if (v > hi) begin
            hit = 1'b1;
            return t_comp'(hi);
        end
        if (v < -hi - 1) begin
            hit = 1'b1;
            return t_comp'(-hi - 1);
        end
        return t_comp'(v);
    endfunction

    // compute the expected result word of one request word
    function automatic t_result alu_result(input t_req rq);
        t_result res;
        longint  ar, ai, aj, ak, br, bi, bj, bk;
        longint  v [4];
        longint  m [9];
        ar = rq.a[0]; ai = rq.a[1]; aj = rq.a[2]; ak = rq.a[3];
        br = rq.b[0]; bi = rq.b[1]; bj = rq.b[2]; bk = rq.b[3];
        v = '{0, 0, 0, 0};
        case (rq.op)
            OP_ADD: v = '{ar + br, ai + bi, aj + bj, ak + bk};
            OP_SUB: v = '{ar - br, ai - bi, aj - bj, ak - bk};
            OP_QMUL: begin
                v[0] = floor_frac(ar*br - ai*bi - aj*bj - ak*bk);
                v[1] = floor_frac(ai*br + ar*bi - ak*bj + aj*bk);
                v[2] = floor_frac(aj*br + ak*bi + ar*bj - ai*bk);
                v[3] = floor_frac(ak*br - aj*bi + ai*bj + ar*bk);
            end
            OP_CONJ: v = '{ar, -ai, -aj, -ak};
            OP_SCALE: v = '{floor_frac(br*ar), floor_frac(br*ai),
                            floor_frac(br*aj), floor_frac(br*ak)};
            OP_NORM2: v[0] = floor_frac(ar*ar + ai*ai + aj*aj + ak*ak);
            OP_ROT, OP_INVROT: begin
                m[0] = floor_frac(ar*ar + ai*ai - aj*aj - ak*ak);
                m[1] = floor_frac(2 * (ai*aj - ar*ak));
                m[2] = floor_frac(2 * (ar*aj + ai*ak));
                m[3] = floor_frac(2 * (ar*ak + ai*aj));
                m[4] = floor_frac(ar*ar - ai*ai + aj*aj - ak*ak);
                m[5] = floor_frac(2 * (aj*ak - ar*ai));
                m[6] = floor_frac(2 * (ai*ak - ar*aj));
                m[7] = floor_frac(2 * (ar*ai + aj*ak));
                m[8] = floor_frac(ar*ar - ai*ai - aj*aj + ak*ak);
                if (rq.op == OP_ROT) begin
                    v[1] = floor_frac(m[0]*bi + m[1]*bj + m[2]*bk);
                    v[2] = floor_frac(m[3]*bi + m[4]*bj + m[5]*bk);
                    v[3] = floor_frac(m[6]*bi + m[7]*bj + m[8]*bk);
                end else begin
                    v[1] = floor_frac(m[0]*bi + m[3]*bj + m[6]*bk);
                    v[2] = floor_frac(m[1]*bi + m[4]*bj + m[7]*bk);
                    v[3] = floor_frac(m[2]*bi + m[5]*bj + m[8]*bk);
                end
            end
            OP_CROSS: begin
                v[1] = floor_frac(aj*bk - ak*bj);
                v[2] = floor_frac(ak*bi - ai*bk);
                v[3] = floor_frac(ai*bj - aj*bi);
            end
            OP_DOT: v[0] = floor_frac(ai*bi + aj*bj + ak*bk);
            OP_COMPMUL: v = '{0, floor_frac(ai*bi), floor_frac(aj*bj),
                              floor_frac(ak*bk)};
            default: ;
        endcase
        res.sat = 1'b0;
        for (int n = 0; n < 4; n++) res.q[n] = clamp_comp(v[n], res.sat);
        return res;
    endfunction

    function automatic t_comp rand_comp();
        case ($urandom_range(0, 5))
            0: return t_comp'(16'h7fff - $urandom_range(0, 3));
            1: return t_comp'(16'h8000 + $urandom_range(0, 3));
            2: return t_comp'($urandom_range(0, 8192) - 4096);
            default: return t_comp'($urandom);
        endcase
    endfunction

    function automatic t_req rand_req();
        t_req rq;
        rq.op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(11, 15))
                                             : 4'($urandom_range(OP_ADD, OP_COMPMUL));
        for (int n = 0; n < 4; n++) begin
            rq.a[n] = rand_comp();
            rq.b[n] = rand_comp();
        end
        return rq;
    endfunction

    function automatic t_row make_row(input logic [3:0] op, input t_comp a, input t_comp b);
        t_row row;
        row.req.op = op;
        row.req.a  = '{a, a, a, a};
        row.req.b  = '{b, b, b, b};
        row.typed  = 1'b0;
        return row;
    endfunction

    // build the directed table: every operation at the extremes, plus typed rows
    task automatic build_table();
        t_row row;
        for (int op = OP_ADD; op <= OP_COMPMUL; op++) begin
            directed_rows.push_back(make_row(4'(op), 16'sh7fff, 16'sh8000));
            directed_rows.push_back(make_row(4'(op), 16'sh8000, 16'sh8000));
        end
        // conjugate of the most negative value clips to the maximum
        row = make_row(OP_CONJ, 16'sh8000, 16'sh0000);
        row.typed = 1'b1;
        row.res.q = '{16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff};
        row.res.sat = 1'b1;
        directed_rows.push_back(row);
        // unused operation codes give all zeros
        row = make_row(4'd15, 16'sh7fff, 16'sh7fff);
        row.typed = 1'b1;
        row.res.q = '{0, 0, 0, 0};
        row.res.sat = 1'b0;
        directed_rows.push_back(row);
        row = make_row(4'd11, 16'sh8000, 16'sh1234);
        row.typed = 1'b1;
        row.res.q = '{0, 0, 0, 0};
        row.res.sat = 1'b0;
        directed_rows.push_back(row);
    endtask

    // place one word on the request channel and wait for acceptance
    task automatic send_word(input t_req rq);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) gap = 0;
        repeat (gap) begin
            i_req.valid <= 1'b0;
            @(negedge i_clk);
        end
        i_req.valid    <= 1'b1;
        i_req.req_type <= rq.op;
        i_req.a_real   <= rq.a[0];
        i_req.a_i      <= rq.a[1];
        i_req.a_j      <= rq.a[2];
        i_req.a_k      <= rq.a[3];
        i_req.b_real   <= rq.b[0];
        i_req.b_i      <= rq.b[1];
        i_req.b_j      <= rq.b[2];
        i_req.b_k      <= rq.b[3];
        do @(posedge i_clk); while (!i_req.ready);
        @(negedge i_clk);
    endtask

    // sender
    initial begin
        t_row row;
        i_rst_n        = 1'b0;
        i_req.valid    = 1'b0;
        i_req.req_type = '0;
        i_req.a_real   = '0;
        i_req.a_i      = '0;
        i_req.a_j      = '0;
        i_req.a_k      = '0;
        i_req.b_real   = '0;
        i_req.b_i      = '0;
        i_req.b_j      = '0;
        i_req.b_k      = '0;
        send_done      = 1'b0;
        build_table();
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        foreach (directed_rows[n]) begin
            if (directed_rows[n].typed)
                pending_results.push_back(directed_rows[n].res);
            else
                pending_results.push_back(alu_result(directed_rows[n].req));
            send_word(directed_rows[n].req);
        end
        for (int n = 0; n < N_RANDOM; n++) begin
            row.req = rand_req();
            pending_results.push_back(alu_result(row.req));
            send_word(row.req);
        end
        i_req.valid <= 1'b0;
        send_done   <= 1'b1;
    end

    // receiver ready: random stalls, one long hold-off early in the random part
    initial begin
        o_rsp.ready = 1'b0;
        hold_off    = 1'b0;
        @(posedge i_rst_n);
        fork
            begin
                repeat (300) @(negedge i_clk);
                hold_off = 1'b1;
                repeat (60) @(negedge i_clk);
                hold_off = 1'b0;
            end
            forever begin
                @(negedge i_clk);
                if (hold_off)
                    o_rsp.ready <= 1'b0;
                else if (cycle_cnt % 400 < 100)
                    o_rsp.ready <= 1'b1;
                else
                    o_rsp.ready <= ($urandom_range(0, 9) == 0) ? 1'b0
                                 : ($urandom_range(0, 3) != 0);
            end
        join
    end

    // check each accepted result word against the oldest expectation
    always @(posedge i_clk) begin
        t_result want;
        t_comp   got [4];
        if (i_rst_n && o_rsp.valid && o_rsp.ready) begin
            got = '{o_rsp.out_real, o_rsp.out_i, o_rsp.out_j, o_rsp.out_k};
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result word %p", $realtime, got);
                err_cnt++;
            end else begin
                want = pending_results.pop_front();
                for (int n = 0; n < 4; n++)
                    if (got[n] !== want.q[n]) begin
                        $display("%0t: component %0d expected %0d actual %0d",
                                 $realtime, n, want.q[n], got[n]);
                        err_cnt++;
                    end
                if (o_rsp.saturated !== want.sat) begin
                    $display("%0t: saturated expected %0b actual %0b",
                             $realtime, want.sat, o_rsp.saturated);
                    err_cnt++;
                end
            end
        end
    end

    // cycle counter and timeout
    initial begin
        cycle_cnt = 0;
        err_cnt   = 0;
        forever begin
            @(posedge i_clk);
            cycle_cnt++;
            if (cycle_cnt > CYCLE_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // end of run
    initial begin
        wait (send_done);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (err_cnt == 0 && pending_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
